@@ rtl/core/rdmc_pkg.sv @@
package rdmc_pkg;

  // field widths
  localparam int CMD_W      = 2;
  localparam int ANGLE_W    = 9;
  localparam int SPEED_W    = 16;
  localparam int PRESET_W   = 32;
  localparam int DRIVE_W    = 17;
  localparam int POS_W      = 32;
  localparam int TARGET_W   = 20;
  localparam int TORQUE_W   = 15;
  localparam int RADIUS_W   = 16;
  localparam int HELD_W     = 14;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_ADDR_W-1:0] CFG_TARGET_LENGTH = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_DRIVE_TORQUE  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_BRAKE_REQUEST = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_WHEEL_RADIUS  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_HAS_SUB_MOTOR = 3'd4;

  // commands
  localparam logic [CMD_W-1:0] CMD_FEEDBACK = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ARM      = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PRESET   = 2'd2;

  // angle unwrapping
  localparam int ANGLE_STEPS = 360;
  localparam int DELTA_W     = $clog2(ANGLE_STEPS + (1 << ANGLE_W)) + 1;
  localparam int WRAP_W      = 18;

  // stop threshold on speed
  localparam logic signed [SPEED_W-1:0] STOP_SPEED = 16'sd1500;

  // travel scale 0.01744 as 1143 / 2^16, compared against target * 36
  localparam int TRAVEL_K    = 1143;
  localparam int TRAVEL_K_W  = 11;
  localparam int SCALE_SHIFT = 16;
  localparam int TARGET_MUL  = 36;
  localparam int T36_W       = TARGET_W + 6;

  // digit-serial multiply over the radius
  localparam int DIG_W      = 4;
  localparam int RAD_DIGITS = RADIUS_W / DIG_W;
  localparam int CNT_W      = $clog2(RAD_DIGITS);
  localparam int MK_W       = POS_W + 1 + TRAVEL_K_W + 1;
  localparam int PP_W       = MK_W + DIG_W + 1;
  localparam int ACC_W      = MK_W + RADIUS_W;

endpackage

@@ rtl/core/rdmc_in_if.sv @@
interface rdmc_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [rdmc_pkg::CMD_W-1:0]           cmd;
  logic [rdmc_pkg::ANGLE_W-1:0]         angle;
  logic signed [rdmc_pkg::SPEED_W-1:0]  speed;
  logic signed [rdmc_pkg::PRESET_W-1:0] preset_value;

  modport source (output valid, cmd, angle, speed, preset_value, input ready);
  modport sink   (input valid, cmd, angle, speed, preset_value, output ready);
endinterface

@@ rtl/core/rdmc_out_if.sv @@
interface rdmc_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [rdmc_pkg::DRIVE_W-1:0] main_drive;
  logic signed [rdmc_pkg::DRIVE_W-1:0] sub_drive;
  logic                                drive_update;
  logic                                stopped;
  logic                                braking;
  logic signed [rdmc_pkg::POS_W-1:0]   position_sum;

  modport source (output valid, main_drive, sub_drive, drive_update, stopped, braking,
                  position_sum, input ready);
  modport sink   (input valid, main_drive, sub_drive, drive_update, stopped, braking,
                  position_sum, output ready);
endinterface

@@ rtl/core/rotation_distance_move_controller.sv @@
// Move controller for a wheel driven by a rotor with an absolute angle sensor. Each
// feedback item (cmd 0) unwraps the angle step by the sign of the speed, adds it to the
// move and position sums and returns the drive command: full torque, half torque from
// half the target length, then a 4x reverse pulse at the target or when a brake was
// armed; once the pulse has slowed the rotor to 1500 or below the drive is written as
// zero and the block reports stopped until the next arm (cmd 1). cmd 2 presets the
// position sum. One item is in work at a time. Arm, preset, unused-command and stopped
// feedback items go from acceptance through S_DONE into the result register, and the
// input takes the next item only once that one has left; a feedback item that evaluates
// the travel goes through S_PREP (move_sum * 1143), S_MULT (the 4-bit-digit serial
// multiply by wheel_radius over its four digits), S_CMP (compare) and S_DONE (output)
// before the input is ready again. A waiting result stalls only the final output cycle.
// Registers are written through cfg_we/cfg_addr/cfg_wdata; the user must do so only while
// no item is in work, as the block does not enforce it. wheel_radius, target_length and
// has_sub_motor are used live, drive_torque and brake_request are taken at arm.
module rotation_distance_move_controller (
  input  logic                              clk,
  input  logic                              rst_n,
  rdmc_in_if.sink                           in_ch,
  rdmc_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [rdmc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [rdmc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int DW   = rdmc_pkg::DELTA_W;
  localparam int WW   = rdmc_pkg::WRAP_W;
  localparam int PW   = rdmc_pkg::POS_W;
  localparam int HW   = rdmc_pkg::HELD_W;
  localparam int AW   = rdmc_pkg::ACC_W;
  localparam int MW   = rdmc_pkg::MK_W;
  localparam int RW   = rdmc_pkg::RADIUS_W;
  localparam int DGW  = rdmc_pkg::DIG_W;
  localparam int CW   = rdmc_pkg::CNT_W;
  localparam int OW   = rdmc_pkg::DRIVE_W;
  localparam int TW   = rdmc_pkg::TORQUE_W;
  localparam int SH   = rdmc_pkg::SCALE_SHIFT;
  localparam int T36W = rdmc_pkg::T36_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_MULT = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  localparam logic [2:0] MODE_NONE  = 3'd0;
  localparam logic [2:0] MODE_ZERO  = 3'd1;
  localparam logic [2:0] MODE_FULL  = 3'd2;
  localparam logic [2:0] MODE_HALF  = 3'd3;
  localparam logic [2:0] MODE_PULSE = 3'd4;
  localparam logic [2:0] MODE_CALC  = 3'd5;

  localparam logic signed [WW-1:0] STEPS_S = WW'(rdmc_pkg::ANGLE_STEPS);
  localparam logic [CW-1:0]        CNT_LAST = CW'(rdmc_pkg::RAD_DIGITS - 1);
  localparam logic [HW-1:0]        HELD_MAX = '1;
  localparam logic signed [MW-1:0] K_S = MW'(rdmc_pkg::TRAVEL_K);

  // configuration registers
  logic [rdmc_pkg::TARGET_W-1:0]    target_r;
  logic signed [TW-1:0]             torque_r;
  logic                             brake_req_r;
  logic [RW-1:0]                    radius_r;
  logic                             sub_en_r;

  // control and move state
  logic [2:0]                       state_r, state_nxt;
  logic [2:0]                       mode_r, mode_nxt;
  logic [CW-1:0]                    cnt_r, cnt_nxt;
  logic [rdmc_pkg::ANGLE_W-1:0]     last_angle_r, last_angle_nxt;
  logic signed [DW-1:0]             last_delta_r, last_delta_nxt;
  logic [PW-1:0]                    pos_total_r, pos_total_nxt;
  logic [PW-1:0]                    move_total_r, move_total_nxt;
  logic [HW-1:0]                    held_torque_r, held_torque_nxt;
  logic                             held_rev_r, held_rev_nxt;
  logic                             stop_r, stop_nxt;
  logic                             pulse_r, pulse_nxt;
  logic                             brake_pend_r, brake_pend_nxt;
  logic                             out_valid_r, out_valid_nxt;

  // datapath registers
  logic signed [MW-1:0]             mk_r, mk_nxt;
  logic signed [AW-1:0]             acc_r, acc_nxt;
  logic [RW-1:0]                    rad_sr_r, rad_sr_nxt;
  logic signed [OW-1:0]             out_main_r, out_main_nxt;
  logic signed [OW-1:0]             out_sub_r, out_sub_nxt;
  logic                             out_upd_r, out_upd_nxt;
  logic                             out_stop_r, out_stop_nxt;
  logic                             out_brk_r, out_brk_nxt;
  logic [PW-1:0]                    out_pos_r, out_pos_nxt;

  // combinational helpers
  logic                             accept;
  logic                             out_free;
  logic signed [WW-1:0]             ang_s, last_s, delta_w;
  logic signed [DW-1:0]             delta_d;
  logic [PW-1:0]                    delta_32;
  logic                             stop_hit;
  logic signed [MW-1:0]             mv_s;
  logic signed [rdmc_pkg::PP_W-1:0] pp;
  logic [T36W-1:0]                  t36;
  logic [T36W-1:0]                  t18;
  logic signed [AW-1:0]             full_s, half_s;
  logic signed [TW:0]               tq_mag;
  logic [OW-1:0]                    drv_mag;
  logic                             drv_neg;
  logic signed [OW-1:0]             drv_main;

  assign accept       = in_ch.valid && in_ch.ready;
  assign out_free     = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE);

  assign out_ch.valid        = out_valid_r;
  assign out_ch.main_drive   = out_main_r;
  assign out_ch.sub_drive    = out_sub_r;
  assign out_ch.drive_update = out_upd_r;
  assign out_ch.stopped      = out_stop_r;
  assign out_ch.braking      = out_brk_r;
  assign out_ch.position_sum = out_pos_r;

  // angle unwrapping by speed sign
  always_comb begin
    ang_s   = WW'(signed'({1'b0, in_ch.angle}));
    last_s  = WW'(signed'({1'b0, last_angle_r}));
    delta_w = WW'(last_delta_r);
    if (in_ch.speed > 0) begin
      if (ang_s < last_s) delta_w = (STEPS_S - last_s) + ang_s;
      else if (ang_s > last_s) delta_w = ang_s - last_s;
    end else if (in_ch.speed < 0) begin
      if (ang_s > last_s) delta_w = -((STEPS_S - ang_s) + last_s);
      else if (ang_s < last_s) delta_w = ang_s - last_s;
    end
    if (in_ch.angle == last_angle_r) delta_w = '0;
    delta_d  = delta_w[DW-1:0];
    delta_32 = {{(PW-DW){delta_d[DW-1]}}, delta_d};
  end

  // brake pulse has slowed the rotor enough
  assign stop_hit = pulse_r && (held_rev_r ? (in_ch.speed >= -rdmc_pkg::STOP_SPEED)
                                           : (in_ch.speed <= rdmc_pkg::STOP_SPEED));

  // signed move sum in drive direction, one radius digit product
  assign mv_s = held_rev_r ? -MW'(signed'(move_total_r)) : MW'(signed'(move_total_r));
  assign pp   = mk_r * signed'({1'b0, rad_sr_r[RW-1 -: DGW]});

  // thresholds: target * 36 * 2^16 and half of it
  assign t36    = T36W'(target_r) * T36W'(rdmc_pkg::TARGET_MUL);
  assign t18    = t36 >> 1;
  assign full_s = signed'({{(AW-T36W-SH){1'b0}}, t36, {SH{1'b0}}});
  assign half_s = signed'({{(AW-T36W-SH){1'b0}}, t18, {SH{1'b0}}});

  // torque magnitude taken at arm
  assign tq_mag = (torque_r > 0) ? (TW+1)'(torque_r) : -(TW+1)'(torque_r);

  // drive value from the resolved mode
  always_comb begin
    drv_neg = held_rev_r;
    case (mode_r)
      MODE_FULL:  drv_mag = OW'(held_torque_r);
      MODE_HALF:  drv_mag = OW'(held_torque_r >> 1);
      MODE_PULSE: begin
        drv_mag = {1'b0, held_torque_r, 2'b00};
        drv_neg = !held_rev_r;
      end
      default:    drv_mag = '0;
    endcase
    drv_main = drv_neg ? -signed'(drv_mag) : signed'(drv_mag);
  end

  // sequencer
  always_comb begin
    state_nxt       = state_r;
    mode_nxt        = mode_r;
    cnt_nxt         = cnt_r;
    last_angle_nxt  = last_angle_r;
    last_delta_nxt  = last_delta_r;
    pos_total_nxt   = pos_total_r;
    move_total_nxt  = move_total_r;
    held_torque_nxt = held_torque_r;
    held_rev_nxt    = held_rev_r;
    stop_nxt        = stop_r;
    pulse_nxt       = pulse_r;
    brake_pend_nxt  = brake_pend_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    mk_nxt          = mk_r;
    acc_nxt         = acc_r;
    rad_sr_nxt      = rad_sr_r;
    out_main_nxt    = out_main_r;
    out_sub_nxt     = out_sub_r;
    out_upd_nxt     = out_upd_r;
    out_stop_nxt    = out_stop_r;
    out_brk_nxt     = out_brk_r;
    out_pos_nxt     = out_pos_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          mode_nxt  = MODE_NONE;
          state_nxt = S_DONE;
          unique case (in_ch.cmd)
            rdmc_pkg::CMD_ARM: begin
              if (!brake_req_r) begin
                held_rev_nxt    = !(torque_r > 0);
                held_torque_nxt = (tq_mag > (TW+1)'(HELD_MAX)) ? HELD_MAX : tq_mag[HW-1:0];
              end
              brake_pend_nxt = brake_req_r;
              move_total_nxt = '0;
              last_delta_nxt = '0;
              stop_nxt       = 1'b0;
            end
            rdmc_pkg::CMD_PRESET: begin
              pos_total_nxt = in_ch.preset_value;
            end
            rdmc_pkg::CMD_FEEDBACK: begin
              pos_total_nxt  = pos_total_r + delta_32;
              move_total_nxt = move_total_r + delta_32;
              last_angle_nxt = in_ch.angle;
              if (stop_hit) begin
                stop_nxt       = 1'b1;
                brake_pend_nxt = 1'b0;
                pulse_nxt      = 1'b0;
                mode_nxt       = MODE_ZERO;
                last_delta_nxt = '0;
              end else if (stop_r) begin
                last_delta_nxt = (in_ch.speed == 0) ? '0 : delta_d;
              end else begin
                last_delta_nxt = delta_d;
                mode_nxt       = MODE_CALC;
                state_nxt      = S_PREP;
              end
            end
            default: ;
          endcase
        end
      end
      S_PREP: begin
        mk_nxt     = mv_s * K_S;
        acc_nxt    = '0;
        rad_sr_nxt = radius_r;
        cnt_nxt    = '0;
        state_nxt  = S_MULT;
      end
      S_MULT: begin
        // msb digit first: acc = acc * 16 + mk * digit
        acc_nxt    = (acc_r <<< DGW) + AW'(pp);
        rad_sr_nxt = rad_sr_r << DGW;
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) state_nxt = S_CMP;
      end
      S_CMP: begin
        if (acc_r >= full_s || brake_pend_r) begin
          mode_nxt  = MODE_PULSE;
          pulse_nxt = 1'b1;
        end else if (acc_r >= half_s) begin
          mode_nxt = MODE_HALF;
        end else begin
          mode_nxt = MODE_FULL;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_main_nxt  = drv_main;
          out_sub_nxt   = sub_en_r ? -drv_main : '0;
          out_upd_nxt   = (mode_r != MODE_NONE);
          out_stop_nxt  = stop_r;
          out_brk_nxt   = pulse_r;
          out_pos_nxt   = pos_total_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      mode_r        <= MODE_NONE;
      cnt_r         <= '0;
      last_angle_r  <= '0;
      last_delta_r  <= '0;
      pos_total_r   <= '0;
      move_total_r  <= '0;
      held_torque_r <= '0;
      held_rev_r    <= 1'b0;
      stop_r        <= 1'b0;
      pulse_r       <= 1'b0;
      brake_pend_r  <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      mode_r        <= mode_nxt;
      cnt_r         <= cnt_nxt;
      last_angle_r  <= last_angle_nxt;
      last_delta_r  <= last_delta_nxt;
      pos_total_r   <= pos_total_nxt;
      move_total_r  <= move_total_nxt;
      held_torque_r <= held_torque_nxt;
      held_rev_r    <= held_rev_nxt;
      stop_r        <= stop_nxt;
      pulse_r       <= pulse_nxt;
      brake_pend_r  <= brake_pend_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // datapath and result payload
  always_ff @(posedge clk) begin
    mk_r       <= mk_nxt;
    acc_r      <= acc_nxt;
    rad_sr_r   <= rad_sr_nxt;
    out_main_r <= out_main_nxt;
    out_sub_r  <= out_sub_nxt;
    out_upd_r  <= out_upd_nxt;
    out_stop_r <= out_stop_nxt;
    out_brk_r  <= out_brk_nxt;
    out_pos_r  <= out_pos_nxt;
  end

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r    <= '0;
      torque_r    <= '0;
      brake_req_r <= 1'b0;
      radius_r    <= '0;
      sub_en_r    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        rdmc_pkg::CFG_TARGET_LENGTH: target_r    <= cfg_wdata[rdmc_pkg::TARGET_W-1:0];
        rdmc_pkg::CFG_DRIVE_TORQUE:  torque_r    <= signed'(cfg_wdata[TW-1:0]);
        rdmc_pkg::CFG_BRAKE_REQUEST: brake_req_r <= cfg_wdata[0];
        rdmc_pkg::CFG_WHEEL_RADIUS:  radius_r    <= cfg_wdata[RW-1:0];
        rdmc_pkg::CFG_HAS_SUB_MOTOR: sub_en_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  // a stopped move never has a brake pulse running
  assert property (@(posedge clk) disable iff (!rst_n) stop_r |-> !pulse_r)
    else $error("stopped with brake pulse active");

  // the serial multiply only leaves toward the compare
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MULT |=> state_r == S_MULT || state_r == S_CMP)
    else $error("multiply sequence broken");

  // a result without drive update carries zero drive
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_upd_r |-> out_main_r == '0 && out_sub_r == '0)
    else $error("drive value without update");

  // the paired motor is silent when absent
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) && !sub_en_r |-> out_sub_r == '0)
    else $error("sub drive without sub motor");
`endif

endmodule
